// File: rtl/mpfe_pkg.sv
// ----------------------------------------------------------------------------
// mpfe_pkg
// Shared types and constants of the monochrome page frame buffer engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mpfe_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 64;
  localparam int FS_DEPTH   = MAX_WIDTH * MAX_HEIGHT / 8;
  localparam int ADDR_W     = $clog2(FS_DEPTH);

  // register indexes
  localparam logic REG_VP_WIDTH  = 1'b0;
  localparam logic REG_VP_HEIGHT = 1'b1;

  // operation codes on in_tuser
  localparam logic [2:0] FN_WRITE_PIXEL  = 3'd0;
  localparam logic [2:0] FN_INVERT_PIXEL = 3'd1;
  localparam logic [2:0] FN_READ_PIXEL   = 3'd2;
  localparam logic [2:0] FN_FILL_SPAN    = 3'd3;
  localparam logic [2:0] FN_INVERT_SPAN  = 3'd4;
  localparam logic [2:0] FN_COPY_SPAN    = 3'd5;
  localparam logic [2:0] FN_READ_BYTE    = 3'd6;
  localparam logic [2:0] FN_CLEAR_ALL    = 3'd7;

  typedef enum logic [2:0] {
    K_NOP,
    K_READ_PIXEL,
    K_READ_BYTE,
    K_MODIFY,
    K_CLEAR
  } mpfe_kind_t;

  typedef enum logic [1:0] {
    M_CLEAR,
    M_SET,
    M_INVERT,
    M_COPY
  } mpfe_mode_t;

  typedef struct packed {
    logic [8:0] eff_w;
    logic [6:0] eff_h;
  } mpfe_view_t;

  typedef struct packed {
    mpfe_kind_t        kind;
    mpfe_mode_t        mode;
    logic              status;
    logic              fill;
    logic [2:0]        dbit;
    logic [2:0]        sbit;
    logic [ADDR_W-1:0] dst_addr;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] count;
  } mpfe_cmd_t;

endpackage

`default_nettype wire

// File: rtl/mpfe_cfg.sv
// ----------------------------------------------------------------------------
// mpfe_cfg
// Viewport registers on the APB-style port, with saturated effective view.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfe_cfg
  import mpfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  output mpfe_view_t       view
);

  logic [8:0] vp_width_r;
  logic [6:0] vp_height_r;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_width_r  <= 9'd128;
      vp_height_r <= 7'd64;
    end else if (wr_en) begin
      case (cfg_paddr[2])
        REG_VP_WIDTH:  vp_width_r  <= cfg_pwdata[8:0];
        REG_VP_HEIGHT: vp_height_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_VP_WIDTH:  cfg_prdata = 32'(vp_width_r);
      REG_VP_HEIGHT: cfg_prdata = 32'(vp_height_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign view.eff_w = (vp_width_r > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : vp_width_r;
  assign view.eff_h = (vp_height_r > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : vp_height_r;

endmodule

`default_nettype wire

// File: rtl/mpfe_front.sv
// ----------------------------------------------------------------------------
// mpfe_front
// Accepts input words, checks the viewport and turns each into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfe_front
  import mpfe_pkg::*;
(
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic [2:0]  in_tuser,
  input  mpfe_view_t       view,
  input  wire logic        init_done,
  input  wire logic        q_full,
  output logic             q_push,
  output mpfe_cmd_t        q_cmd
);

  logic [7:0]  x_first;
  logic [7:0]  x_last;
  logic [5:0]  row;
  logic [5:0]  src_row;
  logic        color;
  logic [11:0] dst_off;
  logic [11:0] src_off;
  logic        pt_err;
  logic        span_empty;
  logic        span_err;
  logic        copy_err;
  logic [7:0]  h_plus;
  logic [12:0] clr_n;

  assign x_first = in_tdata[7:0];
  assign x_last  = in_tdata[15:8];
  assign row     = in_tdata[21:16];
  assign src_row = in_tdata[27:22];
  assign color   = in_tdata[28];

  assign in_tready = init_done & ~q_full;
  assign q_push    = in_tvalid & in_tready;

  assign dst_off = 12'(view.eff_w) * 12'(row[5:3]);
  assign src_off = 12'(view.eff_w) * 12'(src_row[5:3]);

  assign pt_err     = ({1'b0, x_first} >= view.eff_w) | ({1'b0, row} >= view.eff_h);
  assign span_empty = x_first > x_last;
  assign span_err   = ({1'b0, x_last} >= view.eff_w) | ({1'b0, row} >= view.eff_h);
  assign copy_err   = {1'b0, src_row} >= view.eff_h;

  assign h_plus = {1'b0, view.eff_h} + 8'd7;
  assign clr_n  = 13'(view.eff_w) * 13'(h_plus[6:3]);

  always_comb begin
    q_cmd          = '0;
    q_cmd.kind     = K_NOP;
    q_cmd.mode     = color ? M_SET : M_CLEAR;
    q_cmd.fill     = color;
    q_cmd.dbit     = row[2:0];
    q_cmd.sbit     = src_row[2:0];
    q_cmd.dst_addr = ADDR_W'(dst_off + 12'(x_first));
    q_cmd.src_addr = ADDR_W'(src_off + 12'(x_first));
    q_cmd.count    = ADDR_W'(x_last - x_first);
    case (in_tuser)
      FN_WRITE_PIXEL, FN_INVERT_PIXEL: begin
        q_cmd.count = '0;
        if (in_tuser == FN_INVERT_PIXEL) q_cmd.mode = M_INVERT;
        if (pt_err) q_cmd.status = 1'b1;
        else        q_cmd.kind   = K_MODIFY;
      end
      FN_READ_PIXEL, FN_READ_BYTE: begin
        if (pt_err) q_cmd.status = 1'b1;
        else        q_cmd.kind   = (in_tuser == FN_READ_PIXEL) ? K_READ_PIXEL : K_READ_BYTE;
      end
      FN_FILL_SPAN, FN_INVERT_SPAN, FN_COPY_SPAN: begin
        if (in_tuser == FN_INVERT_SPAN) q_cmd.mode = M_INVERT;
        if (in_tuser == FN_COPY_SPAN)   q_cmd.mode = M_COPY;
        if (!span_empty) begin
          if (span_err || (in_tuser == FN_COPY_SPAN && copy_err)) q_cmd.status = 1'b1;
          else                                                     q_cmd.kind   = K_MODIFY;
        end
      end
      FN_CLEAR_ALL: begin
        q_cmd.dst_addr = '0;
        q_cmd.count    = ADDR_W'(clr_n - 13'd1);
        if (clr_n != 13'd0) q_cmd.kind = K_CLEAR;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mpfe_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mpfe_cmd_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfe_cmd_fifo
  import mpfe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  mpfe_cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output mpfe_cmd_t head,
  output logic      empty
);

  mpfe_cmd_t  entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full  = count_r == 2'd2;
  assign empty = count_r == 2'd0;
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/mpfe_back.sv
// ----------------------------------------------------------------------------
// mpfe_back
// Executes commands on the frame store and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfe_back
  import mpfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  mpfe_cmd_t        head,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             init_done,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ACCESS,
    S_CLEAR,
    S_DONE
  } state_t;

  logic [7:0] mem [FS_DEPTH];

  state_t            state_r, state_nxt;
  mpfe_kind_t        kind_r, kind_nxt;
  mpfe_mode_t        mode_r, mode_nxt;
  logic [2:0]        dbit_r, dbit_nxt;
  logic [2:0]        sbit_r, sbit_nxt;
  logic              fill_r, fill_nxt;
  logic [ADDR_W-1:0] dst_r, dst_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt;
  logic [ADDR_W-1:0] rem_r, rem_nxt;
  logic              pend_status_r, pend_status_nxt;
  logic              pend_pixel_r, pend_pixel_nxt;
  logic [7:0]        pend_byte_r, pend_byte_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic              out_pixel_r, out_pixel_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;

  logic [7:0]        rd_dst_r;
  logic [7:0]        rd_src_r;
  logic [ADDR_W-1:0] raddr_d;
  logic [ADDR_W-1:0] raddr_s;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;

  logic              fin_valid;
  logic              fin_status;
  logic              fin_pixel;
  logic [7:0]        fin_byte;
  logic              out_free;
  logic [7:0]        bit_mask;
  logic              bit_val;

  assign init_done  = state_r != S_INIT;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_byte_r, out_pixel_r, out_status_r};
  assign out_free   = ~out_valid_r | out_tready;
  assign q_pop      = (state_r == S_IDLE) & ~q_empty;

  assign bit_mask = 8'd1 << dbit_r;
  assign bit_val  = (mode_r == M_COPY) ? rd_src_r[sbit_r] : (mode_r == M_SET);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_dst_r <= mem[raddr_d];
    rd_src_r <= mem[raddr_s];
  end

  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    mode_nxt        = mode_r;
    dbit_nxt        = dbit_r;
    sbit_nxt        = sbit_r;
    fill_nxt        = fill_r;
    dst_nxt         = dst_r;
    src_nxt         = src_r;
    rem_nxt         = rem_r;
    pend_status_nxt = pend_status_r;
    pend_pixel_nxt  = pend_pixel_r;
    pend_byte_nxt   = pend_byte_r;
    raddr_d         = dst_r + ADDR_W'(1);
    raddr_s         = src_r + ADDR_W'(1);
    we              = 1'b0;
    waddr           = dst_r;
    wdata           = '0;
    fin_valid       = 1'b0;
    fin_status      = 1'b0;
    fin_pixel       = 1'b0;
    fin_byte        = '0;

    case (state_r)
      S_INIT: begin
        we      = 1'b1;
        dst_nxt = dst_r + ADDR_W'(1);
        if (dst_r == ADDR_W'(FS_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        raddr_d = head.dst_addr;
        raddr_s = head.src_addr;
        if (!q_empty) begin
          kind_nxt = head.kind;
          mode_nxt = head.mode;
          dbit_nxt = head.dbit;
          sbit_nxt = head.sbit;
          fill_nxt = head.fill;
          dst_nxt  = head.dst_addr;
          src_nxt  = head.src_addr;
          rem_nxt  = head.count;
          case (head.kind)
            K_NOP: begin
              fin_valid  = 1'b1;
              fin_status = head.status;
            end
            K_CLEAR: state_nxt = S_CLEAR;
            default: state_nxt = S_ACCESS;
          endcase
        end
      end
      S_ACCESS: begin
        case (kind_r)
          K_MODIFY: begin
            we = 1'b1;
            if (mode_r == M_INVERT) wdata = rd_dst_r ^ bit_mask;
            else if (bit_val)       wdata = rd_dst_r | bit_mask;
            else                    wdata = rd_dst_r & ~bit_mask;
            if (rem_r == '0) begin
              fin_valid = 1'b1;
            end else begin
              rem_nxt = rem_r - ADDR_W'(1);
              dst_nxt = dst_r + ADDR_W'(1);
              src_nxt = src_r + ADDR_W'(1);
            end
          end
          K_READ_PIXEL: begin
            fin_valid = 1'b1;
            fin_pixel = rd_dst_r[dbit_r];
          end
          default: begin
            fin_valid = 1'b1;
            fin_byte  = rd_dst_r;
          end
        endcase
      end
      S_CLEAR: begin
        we      = 1'b1;
        wdata   = {8{fill_r}};
        dst_nxt = dst_r + ADDR_W'(1);
        rem_nxt = rem_r - ADDR_W'(1);
        if (rem_r == '0) fin_valid = 1'b1;
      end
      S_DONE: begin
        fin_valid  = 1'b1;
        fin_status = pend_status_r;
        fin_pixel  = pend_pixel_r;
        fin_byte   = pend_byte_r;
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_pixel_nxt  = out_pixel_r;
    out_byte_nxt   = out_byte_r;
    if (fin_valid) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = fin_status;
        out_pixel_nxt  = fin_pixel;
        out_byte_nxt   = fin_byte;
        state_nxt      = S_IDLE;
      end else begin
        pend_status_nxt = fin_status;
        pend_pixel_nxt  = fin_pixel;
        pend_byte_nxt   = fin_byte;
        state_nxt       = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      dst_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dst_r       <= dst_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r        <= kind_nxt;
    mode_r        <= mode_nxt;
    dbit_r        <= dbit_nxt;
    sbit_r        <= sbit_nxt;
    fill_r        <= fill_nxt;
    src_r         <= src_nxt;
    rem_r         <= rem_nxt;
    pend_status_r <= pend_status_nxt;
    pend_pixel_r  <= pend_pixel_nxt;
    pend_byte_r   <= pend_byte_nxt;
    out_status_r  <= out_status_nxt;
    out_pixel_r   <= out_pixel_nxt;
    out_byte_r    <= out_byte_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/mono_page_framebuffer_engine_top.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_engine_top
// Monochrome page frame store: pixel, span, byte and clear operations.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// in_      in   tvalid/tready        tuser: func; tdata: coordinates, color
// out_     out  tvalid/tready        tdata: status, pixel, page_byte
// cfg_     in   psel/penable/pready  viewport_width @0, viewport_height @4
//
// Pixel and read ops read the store in the idle state and finish in the access
// state, pixel ops with a read-modify-write. Spans do a read-modify-write per
// column; clear writes each byte; rejected or empty ops finish in idle. After
// reset a sweep zeroes all 2048 store bytes with in_tready low. A two-word command
// queue and the output register let input and output stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_page_framebuffer_engine_top
  import mpfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // x_first, x_last, row, src_row, color
  input  wire logic [2:0]  in_tuser,   // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // status, pixel, page_byte
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  mpfe_view_t view;
  mpfe_cmd_t  push_cmd;
  mpfe_cmd_t  head;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  logic       init_done;

  mpfe_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .view        (view)
  );

  mpfe_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .view      (view),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  mpfe_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  mpfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .init_done  (init_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
